// ----- rtl/mbt_pkg.sv -----
package mbt_pkg;

   localparam int N_INPUTS = 2;
   localparam int N_HIDDEN = 2;
   localparam int SIG_ENTRIES = 256;
   localparam int FRAC_BITS = 12;

   localparam int HID_BASE = N_HIDDEN * (N_INPUTS + 1);
   localparam int N_WEIGHTS = HID_BASE + N_HIDDEN + 1;
   localparam int W_AW = $clog2(N_WEIGHTS);
   localparam int X_IW = $clog2(N_INPUTS + 1);
   localparam int Z_IW = $clog2(N_HIDDEN + 1);
   localparam int CNT_W = (X_IW > Z_IW) ? X_IW : Z_IW;
   localparam int SIG_IDX_W = $clog2(SIG_ENTRIES);

   localparam int NET_W = 13;
   localparam int SERR_W = 12;
   localparam int SLOPE_W = FRAC_BITS - 1;
   localparam int ERR_W = FRAC_BITS + 2;

   localparam int MA_W = 18;
   localparam int MB_W = 34;
   localparam int P_W = MA_W + MB_W;
   localparam int ACC_W = 56;

   localparam int RND_CHG = 16 + FRAC_BITS;

   localparam logic signed [15:0] ONE = 16'(1 << FRAC_BITS);

   localparam longint LN2_Q30 = 64'sd744261118;
   localparam longint Q30_ONE = 64'sd1 <<< 30;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOMENTUM = 2'd1;
   localparam logic [15:0] RATE_RESET = 16'h8000;
   localparam logic [15:0] MOMENTUM_RESET = 16'h8000;

   typedef struct packed {
      logic cmd;
      logic [3:0] weight_index;
      logic signed [15:0] weight_value;
      logic signed [15:0] feature_one;
      logic signed [15:0] feature_two;
      logic target;
   } req_payload_type;

   typedef struct packed {
      logic [NET_W-1:0] net_output;
      logic [SERR_W-1:0] sample_error;
   } rsp_payload_type;

   typedef struct packed {
      logic rd_en;
      logic [W_AW-1:0] rd_addr;
      logic [W_AW-1:0] wr_addr;
      logic w_we;
      logic signed [15:0] w_data;
      logic p_we;
      logic signed [15:0] p_data;
   } store_req_type;

   typedef struct packed {
      logic signed [15:0] w_rd;
      logic signed [15:0] p_rd;
   } store_rsp_type;

   typedef logic [NET_W-1:0] sig_table_type [SIG_ENTRIES];

   // Shift and subtract quotient, used only while the sigmoid table is built.
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned q;
      longint unsigned rem;
      int b;
      q = '0;
      rem = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem = rem - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [NET_W-1:0] sig_value(input longint raw);
      longint mag;
      longint x30;
      longint n;
      longint r;
      longint sum;
      longint term;
      longint unsigned e;
      longint unsigned d;
      longint unsigned pos;
      int k;
      mag = (raw < 0) ? -raw : raw;
      x30 = mag <<< (30 - FRAC_BITS);
      n = longint'(udiv64(x30, LN2_Q30));
      r = x30 - n * LN2_Q30;
      sum = Q30_ONE;
      term = Q30_ONE;
      for (k = 1; k <= 14; k++) begin
         term = longint'(udiv64((term * r) >>> 30, 64'(k)));
         if (k[0]) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      e = (n < 63) ? ($unsigned(sum) >> n) : 64'd0;
      d = $unsigned(Q30_ONE) + e;
      pos = udiv64((64'd1 << (FRAC_BITS + 30)) + (d >> 1), d);
      if (raw < 0) begin
         pos = (64'd1 << FRAC_BITS) - pos;
      end
      return pos[NET_W-1:0];
   endfunction

   function automatic sig_table_type build_sig_table();
      sig_table_type t;
      longint zc;
      int k;
      for (k = 0; k < SIG_ENTRIES; k++) begin
         zc = (((2 * longint'(k) + 1) * 32768) >>> SIG_IDX_W) - 32768;
         t[k] = sig_value(zc);
      end
      return t;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

   function automatic logic [NET_W-1:0] sig_lookup(input logic signed [15:0] z);
      logic [15:0] zu;
      logic [31:0] wide;
      zu = {~z[15], z[14:0]};
      wide = 32'(zu) * 32'(SIG_ENTRIES);
      return SIG_TABLE[wide[16 +: SIG_IDX_W]];
   endfunction

   function automatic logic signed [ACC_W-1:0] rnd_shift(input logic signed [ACC_W-1:0] v,
                                                         input int s);
      logic signed [ACC_W-1:0] half;
      logic signed [ACC_W-1:0] t;
      half = '0;
      half[s-1] = 1'b1;
      t = v + half;
      return t >>> s;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
      logic signed [15:0] r;
      if (!v[ACC_W-1] && (|v[ACC_W-2:15])) begin
         r = 16'sh7fff;
      end else if (v[ACC_W-1] && !(&v[ACC_W-2:15])) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/mlp_backprop_momentum_trainer.sv -----
// Online trainer for a 2-2-1 sigmoid network with momentum; weights and features Q4.12, rate and momentum Q0.16.
// The req channel carries one item per transfer: a weight write (cmd 1) or a
// training sample (cmd 0). Each item gives exactly one transfer on the rsp
// channel with the network output and half the squared error (both zero for
// weight writes). The csr channel writes the learning rate (index 0) and the
// momentum (index 1); it is always ready and should be used only while idle.
// Weights and previous changes live in two small synchronous memories; one
// shared multiplier does every product, one per cycle, with registered result.
// A training sample keeps the block busy after its transfer through the forward pass,
// the error terms, the back pass per hidden unit, the update of each weight and done;
// a weight write goes straight to done. No new item is taken until the result moves on.
// The result then sits in an output register, so req_stall drops again while
// a finished result waits for the receiver; a stalled rsp holds its payload,
// and a later result waits in the engine until the output register frees.
// Reset clears the handshake state, sets rate and momentum to 0.5 and makes
// every weight and previous change read as zero.
module mlp_backprop_momentum_trainer (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  mbt_pkg::req_payload_type req_payload,
   output logic rsp_valid,
   input  logic rsp_stall,
   output mbt_pkg::rsp_payload_type rsp_payload,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [mbt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0] rate_ff, rate_in;
   logic [15:0] mom_ff, mom_in;
   logic rsp_valid_ff, rsp_valid_in;
   mbt_pkg::rsp_payload_type rsp_payload_ff;
   mbt_pkg::rsp_payload_type result;
   mbt_pkg::store_req_type st_req;
   mbt_pkg::store_rsp_type st_rsp;
   logic idle;
   logic done;
   logic take;

   assign csr_ready = 1'b1;
   assign req_stall = !idle;
   assign take = done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rate_in = rate_ff;
      mom_in = mom_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mbt_pkg::CSR_LEARNING_RATE: rate_in = csr_data;
            mbt_pkg::CSR_MOMENTUM: mom_in = csr_data;
            default: begin
            end
         endcase
      end
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= mbt_pkg::RATE_RESET;
         mom_ff <= mbt_pkg::MOMENTUM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rate_ff <= rate_in;
         mom_ff <= mom_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   mbt_seq u_seq (
      .clock(clock),
      .reset(reset),
      .start(req_valid && !req_stall),
      .item(req_payload),
      .rate(rate_ff),
      .mom(mom_ff),
      .st_rsp(st_rsp),
      .st_req(st_req),
      .idle(idle),
      .done(done),
      .result(result),
      .take(take)
   );

   mbt_store u_store (
      .clock(clock),
      .reset(reset),
      .req(st_req),
      .rsp(st_rsp)
   );

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("engine accepted an item but did not go busy");

   a_output_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.net_output <= mbt_pkg::NET_W'(mbt_pkg::ONE))
      else $error("network output above one");

   a_error_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.sample_error <= mbt_pkg::SERR_W'(mbt_pkg::ONE >>> 1))
      else $error("sample error above one half");

endmodule

// ----- rtl/mbt_store.sv -----
module mbt_store (
   input  logic clock,
   input  logic reset,
   input  mbt_pkg::store_req_type req,
   output mbt_pkg::store_rsp_type rsp
);

   logic signed [15:0] w_mem [mbt_pkg::N_WEIGHTS];
   logic signed [15:0] p_mem [mbt_pkg::N_WEIGHTS];
   logic [mbt_pkg::N_WEIGHTS-1:0] w_vld_ff;
   logic [mbt_pkg::N_WEIGHTS-1:0] w_vld_in;
   logic [mbt_pkg::N_WEIGHTS-1:0] p_vld_ff;
   logic [mbt_pkg::N_WEIGHTS-1:0] p_vld_in;
   logic signed [15:0] w_q_ff;
   logic signed [15:0] p_q_ff;
   logic w_qv_ff;
   logic w_qv_in;
   logic p_qv_ff;
   logic p_qv_in;

   always_comb begin
      w_vld_in = w_vld_ff;
      p_vld_in = p_vld_ff;
      if (req.w_we) begin
         w_vld_in[req.wr_addr] = 1'b1;
      end
      if (req.p_we) begin
         p_vld_in[req.wr_addr] = 1'b1;
      end
      w_qv_in = req.rd_en ? w_vld_ff[req.rd_addr] : w_qv_ff;
      p_qv_in = req.rd_en ? p_vld_ff[req.rd_addr] : p_qv_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_vld_ff <= '0;
         p_vld_ff <= '0;
         w_qv_ff <= 1'b0;
         p_qv_ff <= 1'b0;
      end else begin
         w_vld_ff <= w_vld_in;
         p_vld_ff <= p_vld_in;
         w_qv_ff <= w_qv_in;
         p_qv_ff <= p_qv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.w_we) begin
         w_mem[req.wr_addr] <= req.w_data;
      end
      if (req.p_we) begin
         p_mem[req.wr_addr] <= req.p_data;
      end
      if (req.rd_en) begin
         w_q_ff <= w_mem[req.rd_addr];
         p_q_ff <= p_mem[req.rd_addr];
      end
   end

   assign rsp.w_rd = w_qv_ff ? w_q_ff : 16'sd0;
   assign rsp.p_rd = p_qv_ff ? p_q_ff : 16'sd0;

endmodule

// ----- rtl/mbt_seq.sv -----
module mbt_seq (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  mbt_pkg::req_payload_type item,
   input  logic [15:0] rate,
   input  logic [15:0] mom,
   input  mbt_pkg::store_rsp_type st_rsp,
   output mbt_pkg::store_req_type st_req,
   output logic idle,
   output logic done,
   output mbt_pkg::rsp_payload_type result,
   input  logic take
);

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_FWD_MUL = 5'd1;
   localparam logic [4:0] ST_FWD_ACC = 5'd2;
   localparam logic [4:0] ST_FWD_ACT = 5'd3;
   localparam logic [4:0] ST_SLY     = 5'd4;
   localparam logic [4:0] ST_SLY_R   = 5'd5;
   localparam logic [4:0] ST_DOUT    = 5'd6;
   localparam logic [4:0] ST_DOUT_R  = 5'd7;
   localparam logic [4:0] ST_SERR    = 5'd8;
   localparam logic [4:0] ST_SERR_R  = 5'd9;
   localparam logic [4:0] ST_BK_MUL  = 5'd10;
   localparam logic [4:0] ST_BK_RS   = 5'd11;
   localparam logic [4:0] ST_BK_SL   = 5'd12;
   localparam logic [4:0] ST_BK_SLR  = 5'd13;
   localparam logic [4:0] ST_BK_DH   = 5'd14;
   localparam logic [4:0] ST_BK_DHR  = 5'd15;
   localparam logic [4:0] ST_UP_M1   = 5'd16;
   localparam logic [4:0] ST_UP_M2   = 5'd17;
   localparam logic [4:0] ST_UP_M3   = 5'd18;
   localparam logic [4:0] ST_UP_WB   = 5'd19;
   localparam logic [4:0] ST_DONE    = 5'd20;

   logic [4:0] state_ff, state_in;
   logic [mbt_pkg::Z_IW-1:0] h_ff, h_in;
   logic [mbt_pkg::CNT_W-1:0] i_ff, i_in;
   logic [mbt_pkg::W_AW-1:0] addr_ff, addr_in;
   logic signed [15:0] x_ff [mbt_pkg::N_INPUTS+1];
   logic signed [15:0] x_in [mbt_pkg::N_INPUTS+1];
   logic [mbt_pkg::NET_W-1:0] z_ff [mbt_pkg::N_HIDDEN+1];
   logic [mbt_pkg::NET_W-1:0] z_in [mbt_pkg::N_HIDDEN+1];
   logic signed [15:0] dh_ff [mbt_pkg::N_HIDDEN+1];
   logic signed [15:0] dh_in [mbt_pkg::N_HIDDEN+1];
   logic signed [mbt_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic signed [mbt_pkg::P_W-1:0] prod_ff, prod_in;
   logic [mbt_pkg::NET_W-1:0] sy_ff, sy_in;
   logic signed [mbt_pkg::ERR_W-1:0] err_ff, err_in;
   logic [mbt_pkg::SLOPE_W-1:0] slope_ff, slope_in;
   logic signed [15:0] dout_ff, dout_in;
   logic signed [15:0] back_ff, back_in;
   logic [mbt_pkg::SERR_W-1:0] serr_ff, serr_in;
   logic target_ff, target_in;

   logic signed [mbt_pkg::MA_W-1:0] mul_a;
   logic signed [mbt_pkg::MB_W-1:0] mul_b;
   logic signed [15:0] x_act;
   logic signed [15:0] z_act;
   logic signed [15:0] sy_act;
   logic signed [15:0] dh_sel;
   logic out_h;
   logic last_in;
   logic signed [mbt_pkg::ACC_W-1:0] prod_ext;
   logic signed [mbt_pkg::ACC_W-1:0] prod_rnd;
   logic signed [mbt_pkg::ACC_W-1:0] prod_rnd1;
   logic signed [15:0] prod_sat;
   logic [mbt_pkg::NET_W-1:0] sig_now;
   logic signed [mbt_pkg::ERR_W-1:0] sig_e;
   logic signed [mbt_pkg::ACC_W-1:0] wb_sum;
   logic signed [15:0] chg;
   logic signed [15:0] new_w;
   logic [mbt_pkg::Z_IW-1:0] h_next;

   always_comb begin
      x_act = x_ff[i_ff[mbt_pkg::X_IW-1:0]];
      z_act = $signed(16'(z_ff[i_ff[mbt_pkg::Z_IW-1:0]]));
      sy_act = $signed(16'(sy_ff));
      h_next = h_ff + 1'b1;
      dh_sel = dh_ff[h_next];
      out_h = (h_ff == mbt_pkg::Z_IW'(mbt_pkg::N_HIDDEN));
      last_in = out_h ? (i_ff == mbt_pkg::CNT_W'(mbt_pkg::N_HIDDEN))
                      : (i_ff == mbt_pkg::CNT_W'(mbt_pkg::N_INPUTS));
      prod_ext = mbt_pkg::ACC_W'(prod_ff);
      prod_rnd = mbt_pkg::rnd_shift(prod_ext, mbt_pkg::FRAC_BITS);
      prod_rnd1 = mbt_pkg::rnd_shift(prod_ext, mbt_pkg::FRAC_BITS + 1);
      prod_sat = mbt_pkg::sat16(prod_rnd);
      sig_now = mbt_pkg::sig_lookup(
         mbt_pkg::sat16(mbt_pkg::rnd_shift(acc_ff, mbt_pkg::FRAC_BITS)));
      sig_e = $signed(mbt_pkg::ERR_W'(sig_now));
      wb_sum = acc_ff + (prod_ext <<< mbt_pkg::FRAC_BITS);
      chg = mbt_pkg::sat16(mbt_pkg::rnd_shift(wb_sum, mbt_pkg::RND_CHG));
      new_w = mbt_pkg::sat16(mbt_pkg::ACC_W'(st_rsp.w_rd) + mbt_pkg::ACC_W'(chg));
   end

   always_comb begin
      unique case (state_ff)
         ST_FWD_MUL: begin
            mul_a = mbt_pkg::MA_W'(st_rsp.w_rd);
            mul_b = mbt_pkg::MB_W'(out_h ? z_act : x_act);
         end
         ST_SLY: begin
            mul_a = mbt_pkg::MA_W'(sy_act);
            mul_b = mbt_pkg::MB_W'(mbt_pkg::ONE - sy_act);
         end
         ST_DOUT: begin
            mul_a = mbt_pkg::MA_W'(err_ff);
            mul_b = mbt_pkg::MB_W'($signed(16'(slope_ff)));
         end
         ST_SERR: begin
            mul_a = mbt_pkg::MA_W'(err_ff);
            mul_b = mbt_pkg::MB_W'(err_ff);
         end
         ST_BK_MUL: begin
            mul_a = mbt_pkg::MA_W'(dout_ff);
            mul_b = mbt_pkg::MB_W'(st_rsp.w_rd);
         end
         ST_BK_SL: begin
            mul_a = mbt_pkg::MA_W'(z_act);
            mul_b = mbt_pkg::MB_W'(mbt_pkg::ONE - z_act);
         end
         ST_BK_DH: begin
            mul_a = mbt_pkg::MA_W'(back_ff);
            mul_b = mbt_pkg::MB_W'($signed(16'(slope_ff)));
         end
         ST_UP_M1: begin
            mul_a = mbt_pkg::MA_W'(out_h ? dout_ff : dh_sel);
            mul_b = mbt_pkg::MB_W'(out_h ? z_act : x_act);
         end
         ST_UP_M2: begin
            mul_a = $signed({2'b00, rate});
            mul_b = prod_ff[mbt_pkg::MB_W-1:0];
         end
         ST_UP_M3: begin
            mul_a = $signed({2'b00, mom});
            mul_b = mbt_pkg::MB_W'(st_rsp.p_rd);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mbt_pkg::P_W'(mul_a) * mbt_pkg::P_W'(mul_b);
   end

   always_comb begin
      state_in = state_ff;
      h_in = h_ff;
      i_in = i_ff;
      addr_in = addr_ff;
      x_in = x_ff;
      z_in = z_ff;
      dh_in = dh_ff;
      acc_in = acc_ff;
      sy_in = sy_ff;
      err_in = err_ff;
      slope_in = slope_ff;
      dout_in = dout_ff;
      back_in = back_ff;
      serr_in = serr_ff;
      target_in = target_ff;
      st_req = '0;
      st_req.rd_addr = addr_ff + 1'b1;
      st_req.wr_addr = addr_ff;
      idle = 1'b0;
      done = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               if (item.cmd) begin
                  if (32'(item.weight_index) < mbt_pkg::N_WEIGHTS) begin
                     st_req.w_we = 1'b1;
                     st_req.wr_addr = mbt_pkg::W_AW'(item.weight_index);
                     st_req.w_data = item.weight_value;
                  end
                  sy_in = '0;
                  serr_in = '0;
                  state_in = ST_DONE;
               end else begin
                  for (int k = 0; k <= mbt_pkg::N_INPUTS; k++) begin
                     if (k == 0) begin
                        x_in[k] = mbt_pkg::ONE;
                     end else if (k == 1) begin
                        x_in[k] = item.feature_one;
                     end else if (k == 2) begin
                        x_in[k] = item.feature_two;
                     end else begin
                        x_in[k] = 16'sd0;
                     end
                  end
                  z_in[0] = mbt_pkg::NET_W'(mbt_pkg::ONE);
                  target_in = item.target;
                  acc_in = '0;
                  h_in = '0;
                  i_in = '0;
                  addr_in = '0;
                  st_req.rd_en = 1'b1;
                  st_req.rd_addr = '0;
                  state_in = ST_FWD_MUL;
               end
            end
         end
         ST_FWD_MUL: begin
            state_in = ST_FWD_ACC;
         end
         ST_FWD_ACC: begin
            acc_in = acc_ff + prod_ext;
            if (last_in) begin
               state_in = ST_FWD_ACT;
            end else begin
               i_in = i_ff + 1'b1;
               addr_in = addr_ff + 1'b1;
               st_req.rd_en = 1'b1;
               state_in = ST_FWD_MUL;
            end
         end
         ST_FWD_ACT: begin
            acc_in = '0;
            i_in = '0;
            if (!out_h) begin
               z_in[h_next] = sig_now;
               h_in = h_next;
               addr_in = addr_ff + 1'b1;
               st_req.rd_en = 1'b1;
               state_in = ST_FWD_MUL;
            end else begin
               sy_in = sig_now;
               err_in = target_ff ? (mbt_pkg::ERR_W'(mbt_pkg::ONE) - sig_e) : -sig_e;
               state_in = ST_SLY;
            end
         end
         ST_SLY: begin
            state_in = ST_SLY_R;
         end
         ST_SLY_R: begin
            slope_in = prod_rnd[mbt_pkg::SLOPE_W-1:0];
            state_in = ST_DOUT;
         end
         ST_DOUT: begin
            state_in = ST_DOUT_R;
         end
         ST_DOUT_R: begin
            dout_in = prod_sat;
            state_in = ST_SERR;
         end
         ST_SERR: begin
            state_in = ST_SERR_R;
         end
         ST_SERR_R: begin
            serr_in = prod_rnd1[mbt_pkg::SERR_W-1:0];
            i_in = mbt_pkg::CNT_W'(1);
            addr_in = mbt_pkg::W_AW'(mbt_pkg::HID_BASE + 1);
            st_req.rd_en = 1'b1;
            st_req.rd_addr = mbt_pkg::W_AW'(mbt_pkg::HID_BASE + 1);
            state_in = ST_BK_MUL;
         end
         ST_BK_MUL: begin
            state_in = ST_BK_RS;
         end
         ST_BK_RS: begin
            back_in = prod_sat;
            state_in = ST_BK_SL;
         end
         ST_BK_SL: begin
            state_in = ST_BK_SLR;
         end
         ST_BK_SLR: begin
            slope_in = prod_rnd[mbt_pkg::SLOPE_W-1:0];
            state_in = ST_BK_DH;
         end
         ST_BK_DH: begin
            state_in = ST_BK_DHR;
         end
         ST_BK_DHR: begin
            dh_in[i_ff[mbt_pkg::Z_IW-1:0]] = prod_sat;
            if (i_ff == mbt_pkg::CNT_W'(mbt_pkg::N_HIDDEN)) begin
               i_in = '0;
               h_in = '0;
               addr_in = '0;
               st_req.rd_en = 1'b1;
               st_req.rd_addr = '0;
               state_in = ST_UP_M1;
            end else begin
               i_in = i_ff + 1'b1;
               addr_in = addr_ff + 1'b1;
               st_req.rd_en = 1'b1;
               state_in = ST_BK_MUL;
            end
         end
         ST_UP_M1: begin
            state_in = ST_UP_M2;
         end
         ST_UP_M2: begin
            state_in = ST_UP_M3;
         end
         ST_UP_M3: begin
            acc_in = prod_ext;
            state_in = ST_UP_WB;
         end
         ST_UP_WB: begin
            st_req.w_we = 1'b1;
            st_req.w_data = new_w;
            st_req.p_we = 1'b1;
            st_req.p_data = chg;
            if (addr_ff == mbt_pkg::W_AW'(mbt_pkg::N_WEIGHTS - 1)) begin
               state_in = ST_DONE;
            end else begin
               addr_in = addr_ff + 1'b1;
               st_req.rd_en = 1'b1;
               if (last_in) begin
                  i_in = '0;
                  h_in = h_next;
               end else begin
                  i_in = i_ff + 1'b1;
               end
               state_in = ST_UP_M1;
            end
         end
         ST_DONE: begin
            done = 1'b1;
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      i_ff <= i_in;
      addr_ff <= addr_in;
      x_ff <= x_in;
      z_ff <= z_in;
      dh_ff <= dh_in;
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      sy_ff <= sy_in;
      err_ff <= err_in;
      slope_ff <= slope_in;
      dout_ff <= dout_in;
      back_ff <= back_in;
      serr_ff <= serr_in;
      target_ff <= target_in;
   end

   assign result.net_output = sy_ff;
   assign result.sample_error = serr_ff;

endmodule

// ----- bench/mlp_backprop_momentum_trainer_test.sv -----
module mlp_backprop_momentum_trainer_test;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 200;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   mbt_pkg::req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   mbt_pkg::rsp_payload_type rsp_payload;
   logic csr_valid;
   logic csr_ready;
   logic [mbt_pkg::CSR_IDX_W-1:0] csr_index;
   logic [15:0] csr_data;

   mbt_pkg::rsp_payload_type expected_results[$];
   longint net_weight[mbt_pkg::N_WEIGHTS];
   longint last_change[mbt_pkg::N_WEIGHTS];
   longint rate_q16;
   longint momentum_q16;
   longint sigmoid_lut[mbt_pkg::SIG_ENTRIES];
   int send_idle_pct;
   int recv_stall_pct;
   int hold_off_cycles;
   int idle_count;
   bit failed;

   mlp_backprop_momentum_trainer dut (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic longint round_shift(longint v, int s);
      longint t;
      t = v + (longint'(1) << (s - 1));
      return t >>> s;
   endfunction

   function automatic longint clamp16(longint v);
      if (v > 32767) begin
         return 32767;
      end
      if (v < -32768) begin
         return -32768;
      end
      return v;
   endfunction

   function automatic longint sigmoid_exact(longint raw);
      longint mag, x30, n, r, sum, term;
      longint unsigned e, d, pos;
      mag = raw < 0 ? -raw : raw;
      x30 = mag * (longint'(1) << (30 - mbt_pkg::FRAC_BITS));
      n = x30 / 744261118;
      r = x30 - n * 744261118;
      sum = longint'(1) << 30;
      term = sum;
      for (int k = 1; k <= 14; k++) begin
         term = longint'((longint'(term) * r) >>> 30) / k;
         sum = (k % 2 == 1) ? sum - term : sum + term;
      end
      e = (n < 63) ? (longint'(sum) >> n) : 0;
      d = (64'd1 << 30) + e;
      pos = ((64'd1 << (mbt_pkg::FRAC_BITS + 30)) + d / 2) / d;
      if (raw < 0) begin
         pos = (64'd1 << mbt_pkg::FRAC_BITS) - pos;
      end
      return longint'(pos);
   endfunction

   function automatic longint squash(longint z);
      longint idx;
      idx = ((z + 32768) * mbt_pkg::SIG_ENTRIES) >>> 16;
      if (idx >= mbt_pkg::SIG_ENTRIES) begin
         idx = mbt_pkg::SIG_ENTRIES - 1;
      end
      return sigmoid_lut[idx];
   endfunction

   function automatic longint slope(longint s);
      return round_shift(s * ((longint'(1) << mbt_pkg::FRAC_BITS) - s), mbt_pkg::FRAC_BITS);
   endfunction

   function automatic longint weight_change(longint delta, longint act, longint prev);
      return clamp16(round_shift(rate_q16 * delta * act
                                 + momentum_q16 * prev * (longint'(1) << mbt_pkg::FRAC_BITS),
                                 16 + mbt_pkg::FRAC_BITS));
   endfunction

   function automatic mbt_pkg::rsp_payload_type train_step(mbt_pkg::req_payload_type item);
      mbt_pkg::rsp_payload_type res;
      longint act_in[mbt_pkg::N_INPUTS + 1];
      longint act_hid[mbt_pkg::N_HIDDEN + 1];
      longint delta_hid[mbt_pkg::N_HIDDEN + 1];
      longint acc, y, err, dout, back, c;
      int w;
      res = '0;
      if (item.cmd) begin
         if (item.weight_index < mbt_pkg::N_WEIGHTS) begin
            net_weight[item.weight_index] = longint'(item.weight_value);
         end
         return res;
      end
      act_in[0] = 1 << mbt_pkg::FRAC_BITS;
      act_in[1] = longint'(item.feature_one);
      act_in[2] = longint'(item.feature_two);
      act_hid[0] = 1 << mbt_pkg::FRAC_BITS;
      for (int h = 0; h < mbt_pkg::N_HIDDEN; h++) begin
         acc = 0;
         for (int i = 0; i <= mbt_pkg::N_INPUTS; i++) begin
            acc += net_weight[h * (mbt_pkg::N_INPUTS + 1) + i] * act_in[i];
         end
         act_hid[h + 1] = squash(clamp16(round_shift(acc, mbt_pkg::FRAC_BITS)));
      end
      acc = 0;
      for (int h = 0; h <= mbt_pkg::N_HIDDEN; h++) begin
         acc += net_weight[mbt_pkg::HID_BASE + h] * act_hid[h];
      end
      y = squash(clamp16(round_shift(acc, mbt_pkg::FRAC_BITS)));
      err = (item.target ? (1 << mbt_pkg::FRAC_BITS) : 0) - y;
      dout = clamp16(round_shift(err * slope(y), mbt_pkg::FRAC_BITS));
      delta_hid[0] = 0;
      for (int h = 1; h <= mbt_pkg::N_HIDDEN; h++) begin
         back = clamp16(round_shift(dout * net_weight[mbt_pkg::HID_BASE + h],
                                    mbt_pkg::FRAC_BITS));
         delta_hid[h] = clamp16(round_shift(back * slope(act_hid[h]), mbt_pkg::FRAC_BITS));
      end
      for (int h = 0; h <= mbt_pkg::N_HIDDEN; h++) begin
         w = mbt_pkg::HID_BASE + h;
         c = weight_change(dout, act_hid[h], last_change[w]);
         net_weight[w] = clamp16(net_weight[w] + c);
         last_change[w] = c;
      end
      for (int h = 0; h < mbt_pkg::N_HIDDEN; h++) begin
         for (int i = 0; i <= mbt_pkg::N_INPUTS; i++) begin
            w = h * (mbt_pkg::N_INPUTS + 1) + i;
            c = weight_change(delta_hid[h + 1], act_in[i], last_change[w]);
            net_weight[w] = clamp16(net_weight[w] + c);
            last_change[w] = c;
         end
      end
      res.net_output = mbt_pkg::NET_W'(y);
      res.sample_error = mbt_pkg::SERR_W'(round_shift(err * err, mbt_pkg::FRAC_BITS + 1));
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected transfer on rsp: net_output %0d", rsp_payload.net_output);
            failed = 1'b1;
         end else begin
            if (rsp_payload.net_output !== expected_results[0].net_output) begin
               $error("net_output expected %0d actual %0d",
                      expected_results[0].net_output, rsp_payload.net_output);
               failed = 1'b1;
            end
            if (rsp_payload.sample_error !== expected_results[0].sample_error) begin
               $error("sample_error expected %0d actual %0d",
                      expected_results[0].sample_error, rsp_payload.sample_error);
               failed = 1'b1;
            end
            void'(expected_results.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || hold_off_cycles > 0) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic send_item(mbt_pkg::req_payload_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do begin
         @(posedge clock);
      end while (req_stall);
      expected_results.push_back(train_step(item));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [mbt_pkg::CSR_IDX_W-1:0] index, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      if (index == mbt_pkg::CSR_LEARNING_RATE) begin
         rate_q16 = value;
      end else if (index == mbt_pkg::CSR_MOMENTUM) begin
         momentum_q16 = value;
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_weight(int index, logic signed [15:0] value);
      mbt_pkg::req_payload_type item;
      item = '0;
      item.cmd = 1'b1;
      item.weight_index = 4'(index);
      item.weight_value = value;
      send_item(item);
   endtask

   task automatic train_sample(logic signed [15:0] x1, logic signed [15:0] x2, logic t);
      mbt_pkg::req_payload_type item;
      item = mbt_pkg::req_payload_type'($bits(mbt_pkg::req_payload_type)'(
         {$urandom, $urandom, $urandom}));
      item.cmd = 1'b0;
      item.feature_one = x1;
      item.feature_two = x2;
      item.target = t;
      send_item(item);
   endtask

   function automatic logic signed [15:0] random_small();
      return 16'($signed($urandom_range(16384)) - 8192);
   endfunction

   task automatic test_directed();
      train_sample(16'sh0000, 16'sh0000, 1'b1);
      load_weight(0, 16'sh7fff);
      load_weight(1, 16'sh8000);
      load_weight(2, 16'sh7fff);
      load_weight(3, 16'sh8000);
      load_weight(4, 16'sh7fff);
      load_weight(5, 16'sh1000);
      load_weight(6, 16'sh8000);
      load_weight(7, 16'sh7fff);
      load_weight(8, 16'sh8000);
      load_weight(9, 16'sh1234);
      load_weight(15, 16'shffff);
      train_sample(16'sh7fff, 16'sh8000, 1'b0);
      train_sample(16'sh8000, 16'sh7fff, 1'b1);
      train_sample(16'sh7fff, 16'sh7fff, 1'b1);
      train_sample(16'sh8000, 16'sh8000, 1'b0);
      train_sample(16'sh0001, 16'shffff, 1'b1);
   endtask

   task automatic test_rate_extremes();
      wait_drained();
      write_register(mbt_pkg::CSR_LEARNING_RATE, 16'hffff);
      write_register(mbt_pkg::CSR_MOMENTUM, 16'h0000);
      repeat (8) train_sample(random_small(), random_small(), 1'($urandom));
      wait_drained();
      write_register(mbt_pkg::CSR_LEARNING_RATE, 16'h0000);
      write_register(mbt_pkg::CSR_MOMENTUM, 16'hffff);
      repeat (8) train_sample(random_small(), random_small(), 1'($urandom));
      wait_drained();
      write_register(2'd2, 16'h1234);
      write_register(2'd3, 16'h4321);
      write_register(mbt_pkg::CSR_LEARNING_RATE, mbt_pkg::RATE_RESET);
      write_register(mbt_pkg::CSR_MOMENTUM, mbt_pkg::MOMENTUM_RESET);
   endtask

   task automatic random_phase(int count);
      mbt_pkg::req_payload_type item;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 12) begin
            item = mbt_pkg::req_payload_type'($bits(mbt_pkg::req_payload_type)'(
               {$urandom, $urandom, $urandom}));
            item.cmd = 1'b1;
            if ($urandom_range(9) != 0) begin
               item.weight_index = 4'($urandom_range(mbt_pkg::N_WEIGHTS - 1));
            end
            if ($urandom_range(3) != 0) begin
               item.weight_value = random_small();
            end
            send_item(item);
         end else if ($urandom_range(9) == 0) begin
            train_sample(16'($urandom), 16'($urandom), 1'($urandom));
         end else begin
            train_sample(random_small(), random_small(), 1'($urandom));
         end
      end
   endtask

   task automatic test_random_traffic();
      wait_drained();
      write_register(mbt_pkg::CSR_LEARNING_RATE, 16'($urandom_range(2000, 40000)));
      write_register(mbt_pkg::CSR_MOMENTUM, 16'($urandom_range(0, 50000)));
      send_idle_pct = 0;
      recv_stall_pct = 0;
      random_phase(130);
      send_idle_pct = 51;
      random_phase(130);
      send_idle_pct = 0;
      recv_stall_pct = 51;
      random_phase(130);
      send_idle_pct = 18;
      recv_stall_pct = 18;
      random_phase(130);
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   task automatic test_backpressure();
      hold_off_cycles = 600;
      random_phase(10);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      hold_off_cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      failed = 1'b0;
      rate_q16 = mbt_pkg::RATE_RESET;
      momentum_q16 = mbt_pkg::MOMENTUM_RESET;
      for (int k = 0; k < mbt_pkg::SIG_ENTRIES; k++) begin
         sigmoid_lut[k] = sigmoid_exact(((2 * longint'(k) + 1) * 32768)
                                        / mbt_pkg::SIG_ENTRIES - 32768);
      end
      for (int k = 0; k < mbt_pkg::N_WEIGHTS; k++) begin
         net_weight[k] = 0;
         last_change[k] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_rate_extremes();
      test_random_traffic();
      test_backpressure();
      wait_drained();
      if (!failed) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
